FILE: rtl/core/rdma_thp_pkg.sv
`timescale 1ns / 1ps
package rdma_thp_pkg;

  localparam logic [31:0] CrcPoly = 32'h82F63B78;
  localparam logic [31:0] CrcInit = 32'hFFFFFFFF;
  localparam logic [13:0] PosMax  = 14'h3FFF;

  localparam logic [1:0] StatusOk       = 2'd0;
  localparam logic [1:0] StatusShort    = 2'd1;
  localparam logic [1:0] StatusMismatch = 2'd2;

  // Optional header set decoded from the opcode.
  typedef struct packed {
    logic reth;
    logic aeth;
    logic imm;
  } hdr_set_t;

  // Byte beat handed from the front (classify) to the back (capture/CRC).
  typedef struct packed {
    logic [7:0]  byte_value;
    logic        last_byte;
    logic [13:0] pos;
  } beat_t;

  typedef struct packed {
    logic [7:0]  opcode;
    logic [13:0] header_flags;
    logic [15:0] part_key;
    logic [23:0] dest_queue_pair;
    logic [23:0] sequence_number;
    logic [63:0] remote_address;
    logic [31:0] remote_key;
    logic [31:0] xfer_length;
    logic [31:0] ack_word;
    logic [31:0] immediate_data;
    logic [13:0] payload_length;
    logic [1:0]  status;
  } result_t;

  function automatic hdr_set_t header_set(input logic [7:0] op);
    hdr_set_t hs;
    hs = '0;
    case (op) inside
      8'h06, 8'h0A, 8'h0C:        hs.reth = 1'b1;
      8'h0B:                      begin hs.reth = 1'b1; hs.imm = 1'b1; end
      8'h03, 8'h05, 8'h09:        hs.imm = 1'b1;
      8'h0D, 8'h0F, 8'h10, 8'h11: hs.aeth = 1'b1;
      default:                    hs = '0;
    endcase
    return hs;
  endfunction

  function automatic logic [31:0] crc_byte(input logic [31:0] crc, input logic [7:0] b);
    logic [31:0] c;
    c = crc ^ {24'h0, b};
    for (int i = 0; i < 8; i++) begin
      c = c[0] ? ((c >> 1) ^ CrcPoly) : (c >> 1);
    end
    return c;
  endfunction

endpackage

FILE: rtl/core/rdma_thp_if.sv
`timescale 1ns / 1ps
interface rdma_thp_byte_if;
  logic       valid;
  logic       ready;
  logic [7:0] byte_value;
  logic       last_byte;
  modport source (output valid, byte_value, last_byte, input ready);
  modport sink (input valid, byte_value, last_byte, output ready);
endinterface

interface rdma_thp_cfg_if;
  logic valid;
  logic ready;
  logic icrc_check_enable;
  modport source (output valid, icrc_check_enable, input ready);
  modport sink (input valid, icrc_check_enable, output ready);
endinterface

interface rdma_thp_res_if;
  import rdma_thp_pkg::*;
  logic    valid;
  logic    ready;
  result_t res;
  modport source (output valid, res, input ready);
  modport sink (input valid, res, output ready);
endinterface

FILE: rtl/core/rdma_transport_header_parser.sv
`timescale 1ns / 1ps
// RDMA transport header parser: takes one packet byte per beat from the BTH opcode
// through the 4-byte ICRC and, on the beat marked last_byte, posts one result with the
// BTH fields, optional RETH/AETH/immediate fields, payload length and status (only the
// status for a short packet). One byte is accepted per cycle sustained while the result
// output is not stalled; the rate is set by the byte-wide CRC-32C step in the back end. A
// two-entry queue between the front (position tagging) and the back (capture, CRC, result
// register) lets input and output stall independently; with nothing queued ahead and the
// output not stalled, the last byte moves through a queue entry, then the result register.
module rdma_transport_header_parser
  import rdma_thp_pkg::*;
#(
  parameter int MAX_PACKET_BYTES = 8192
) (
  input  logic clk_i,
  input  logic rst_ni,
  rdma_thp_byte_if.sink  in_if,
  rdma_thp_cfg_if.sink   cfg_if,
  rdma_thp_res_if.source res_if
);

  logic  crc_en_q;
  logic  q_valid, q_ready;
  beat_t q_beat;

  assign cfg_if.ready = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) crc_en_q <= 1'b1;
    else if (cfg_if.valid) crc_en_q <= cfg_if.icrc_check_enable;
  end

  rdma_thp_front u_front (
    .clk_i, .rst_ni,
    .in_valid_i(in_if.valid), .in_ready_o(in_if.ready),
    .byte_value_i(in_if.byte_value), .last_byte_i(in_if.last_byte),
    .q_valid_o(q_valid), .q_ready_i(q_ready), .q_beat_o(q_beat)
  );

  rdma_thp_back #(.MaxPacketBytes(MAX_PACKET_BYTES)) u_back (
    .clk_i, .rst_ni, .crc_en_i(crc_en_q),
    .q_valid_i(q_valid), .q_ready_o(q_ready), .q_beat_i(q_beat),
    .res_valid_o(res_if.valid), .res_ready_i(res_if.ready), .res_o(res_if.res)
  );

endmodule

FILE: rtl/core/rdma_thp_front.sv
`timescale 1ns / 1ps
module rdma_thp_front
  import rdma_thp_pkg::*;
(
  input  logic  clk_i,
  input  logic  rst_ni,
  input  logic  in_valid_i,
  output logic  in_ready_o,
  input  logic  [7:0] byte_value_i,
  input  logic  last_byte_i,
  output logic  q_valid_o,
  input  logic  q_ready_i,
  output beat_t q_beat_o
);

  // Two-entry queue; front tags each beat with its packet position.
  logic [13:0] pos_q, pos_d;
  beat_t       mem_q [2];
  logic        wr_ptr_q, rd_ptr_q;
  logic [1:0]  cnt_q;
  logic        push, pop;

  assign in_ready_o = (cnt_q != 2'd2);
  assign push       = in_valid_i && in_ready_o;
  assign q_valid_o  = (cnt_q != 2'd0);
  assign pop        = q_valid_o && q_ready_i;
  assign q_beat_o   = mem_q[rd_ptr_q];

  always_comb begin
    pos_d = pos_q;
    if (push) begin
      if (last_byte_i) pos_d = '0;
      else if (pos_q != PosMax) pos_d = pos_q + 14'd1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pos_q    <= '0;
      wr_ptr_q <= 1'b0;
      rd_ptr_q <= 1'b0;
      cnt_q    <= '0;
    end else begin
      pos_q <= pos_d;
      if (push) wr_ptr_q <= ~wr_ptr_q;
      if (pop)  rd_ptr_q <= ~rd_ptr_q;
      cnt_q <= cnt_q + {1'b0, push} - {1'b0, pop};
    end
  end

  always_ff @(posedge clk_i) begin
    if (push) mem_q[wr_ptr_q] <= '{byte_value: byte_value_i, last_byte: last_byte_i,
                                   pos: pos_q};
  end

  assert property (@(posedge clk_i) disable iff (!rst_ni) cnt_q <= 2'd2)
    else $error("queue count overflow");
  assert property (@(posedge clk_i) disable iff (!rst_ni)
                   (cnt_q == 2'd0) |-> !pop)
    else $error("pop from empty queue");
  assert property (@(posedge clk_i) disable iff (!rst_ni)
                   (push && last_byte_i) |=> pos_q == '0)
    else $error("position not cleared after last beat");

endmodule

FILE: rtl/core/rdma_thp_back.sv
`timescale 1ns / 1ps
module rdma_thp_back
  import rdma_thp_pkg::*;
#(
  parameter int MaxPacketBytes = 8192
) (
  input  logic    clk_i,
  input  logic    rst_ni,
  input  logic    crc_en_i,
  input  logic    q_valid_i,
  output logic    q_ready_o,
  input  beat_t   q_beat_i,
  output logic    res_valid_o,
  input  logic    res_ready_i,
  output result_t res_o
);

  // Payload can never exceed the position range, so a larger cap is no cap.
  localparam logic [13:0] MaxPay = (MaxPacketBytes > 16383) ? PosMax
                                                            : 14'(MaxPacketBytes);

  logic [31:0] crc_q, crc_d;
  logic [31:0] hold_q, hold_d;
  logic [7:0]  op_q;
  logic [10:0] flags_q;
  logic [15:0] pkey_q;
  logic [23:0] qp_q, psn_q;
  logic [63:0] addr_q;
  logic [31:0] rkey_q, len_q, ack_q, imm_q;
  logic        take;
  logic        out_valid_q;
  result_t     out_q, res_d;
  hdr_set_t    hs;
  logic [13:0] p, total, q, hdr_end, pay;
  logic [7:0]  b;
  logic        short;

  assign q_ready_o   = !out_valid_q || res_ready_i;
  assign take        = q_valid_i && q_ready_o;
  assign res_valid_o = out_valid_q;
  assign res_o       = out_q;

  assign p  = q_beat_i.pos;
  assign b  = q_beat_i.byte_value;
  assign hs = header_set(op_q);
  assign q  = p - 14'd12;

  always_comb begin
    crc_d  = (p >= 14'd4) ? crc_byte(crc_q, hold_q[31:24]) : crc_q;
    hold_d = {hold_q[23:0], b};
    total  = (p != PosMax) ? p + 14'd1 : PosMax;
    hdr_end = 14'd12 + (hs.reth ? 14'd16 : 14'd0) + (hs.aeth ? 14'd4 : 14'd0)
            + (hs.imm ? 14'd4 : 14'd0);
    short = (total < 14'd16) || (hdr_end > total - 14'd4);
    pay   = total - 14'd4 - hdr_end;
    if (pay > MaxPay) pay = MaxPay;
    res_d = '0;
    if (short) begin
      res_d.status = StatusShort;
    end else begin
      res_d.opcode          = op_q;
      res_d.header_flags    = {hs.imm, hs.aeth, hs.reth, flags_q};
      res_d.part_key        = pkey_q;
      res_d.dest_queue_pair = qp_q;
      res_d.sequence_number = psn_q;
      res_d.remote_address  = addr_q;
      res_d.remote_key      = rkey_q;
      res_d.xfer_length     = len_q;
      res_d.ack_word        = ack_q;
      res_d.immediate_data  = imm_q;
      res_d.payload_length  = pay;
      res_d.status = (crc_en_i && ((crc_d ^ CrcInit) != hold_d)) ? StatusMismatch : StatusOk;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
      crc_q <= CrcInit; hold_q <= '0; op_q <= '0; flags_q <= '0; pkey_q <= '0;
      qp_q <= '0; psn_q <= '0; addr_q <= '0; rkey_q <= '0; len_q <= '0;
      ack_q <= '0; imm_q <= '0;
    end else begin
      if (res_ready_i) out_valid_q <= 1'b0;
      if (take) begin
        if (q_beat_i.last_byte) begin
          out_valid_q <= 1'b1;
          crc_q <= CrcInit; hold_q <= '0; op_q <= '0; flags_q <= '0; pkey_q <= '0;
          qp_q <= '0; psn_q <= '0; addr_q <= '0; rkey_q <= '0; len_q <= '0;
          ack_q <= '0; imm_q <= '0;
        end else begin
          crc_q  <= crc_d;
          hold_q <= hold_d;
          if (p == 14'd0) op_q <= b;
          else if (p == 14'd1) flags_q[7:0] <= {b[3:0], b[5:4], b[6], b[7]};
          else if (p <= 14'd3) pkey_q <= {pkey_q[7:0], b};
          else if (p == 14'd4) flags_q[9:8] <= {b[6], b[7]};
          else if (p <= 14'd7) qp_q <= {qp_q[15:0], b};
          else if (p == 14'd8) flags_q[10] <= b[7];
          else if (p <= 14'd11) psn_q <= {psn_q[15:0], b};
          else if (hs.reth && q < 14'd8) addr_q <= {addr_q[55:0], b};
          else if (hs.reth && q < 14'd12) rkey_q <= {rkey_q[23:0], b};
          else if (hs.reth && q < 14'd16) len_q <= {len_q[23:0], b};
          else if (hs.aeth && (q - (hs.reth ? 14'd16 : 14'd0)) < 14'd4)
            ack_q <= {ack_q[23:0], b};
          else if (hs.imm && (q - (hs.reth ? 14'd16 : 14'd0)
                   - (hs.aeth ? 14'd4 : 14'd0)) < 14'd4)
            imm_q <= {imm_q[23:0], b};
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (take && q_beat_i.last_byte) out_q <= res_d;
  end

  assert property (@(posedge clk_i) disable iff (!rst_ni)
                   (out_valid_q && !res_ready_i) |-> !q_ready_o)
    else $error("back accepted a beat over a stalled result");
  assert property (@(posedge clk_i) disable iff (!rst_ni)
                   (take && q_beat_i.last_byte) |=> (out_valid_q && crc_q == CrcInit))
    else $error("packet end did not post result and reinit CRC");
  assert property (@(posedge clk_i) disable iff (!rst_ni)
                   out_valid_q |-> out_q.status != 2'd3)
    else $error("invalid status code");

endmodule
